// File: design/fshb_pkg.sv
// Package for the flux sync hunt bit decoder: beat types, decoder command and
// result structs, register indexes, status codes and the sync pattern.
// No dependencies.
package fshb_pkg;

	// Interval class, coded as bit cells minus two
	typedef logic [1:0] class_t;

	localparam class_t CLASS_TWO   = 2'd0;
	localparam class_t CLASS_THREE = 2'd1;
	localparam class_t CLASS_FOUR  = 2'd2;

	// Sync pattern in classes, oldest first
	localparam int SYNC_LEN = 10;
	localparam class_t SYNC_CODES [SYNC_LEN] = '{
		CLASS_FOUR, CLASS_THREE, CLASS_FOUR, CLASS_THREE, CLASS_TWO,
		CLASS_FOUR, CLASS_THREE, CLASS_FOUR, CLASS_THREE, CLASS_TWO
	};

	// Class history depth and hunt counter
	localparam int HIST_LEN = 11;
	localparam int SEEN_W = 4;
	localparam logic [SEEN_W-1:0] SEEN_MAX = 4'd11;

	// Result status codes
	localparam logic [1:0] STATUS_DATA    = 2'd0;
	localparam logic [1:0] STATUS_NO_SYNC = 2'd1;
	localparam logic [1:0] STATUS_FULL    = 2'd2;

	// Configuration register map
	localparam int ADDR_W = 4;
	localparam logic [1:0] REG_LONG_LIMIT = 2'd0;
	localparam logic [1:0] REG_MID_LIMIT  = 2'd1;
	localparam logic [1:0] REG_BYTE_LIMIT = 2'd2;

	localparam logic [15:0] LONG_LIMIT_RST = 16'd700;
	localparam logic [15:0] MID_LIMIT_RST  = 16'd500;
	localparam logic [15:0] BYTE_LIMIT_RST = 16'd11964;

	// Result queue
	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W = 2;
	localparam int LEVEL_W = 3;
	// Highest fill level at which two more beats still fit
	localparam logic [LEVEL_W-1:0] LEVEL_ROOM = 3'd2;

	typedef struct packed {
		logic [15:0] interval_time;
		logic        final_sample;
	} flux_beat_t;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic [15:0] byte_index;
		logic [1:0]  status;
		logic        run_end;
	} byte_beat_t;

	// One cycle of work for the decoder
	typedef struct packed {
		logic   start;     // sync found: enter decoding at cell -2
		logic   step;      // advance by one interval of class code
		class_t code;
		logic   flush;     // last interval of the capture: flush and clear
		logic   item_end;  // this cycle ends the beat's work
	} dec_cmd_t;

	// Up to two result beats produced in one cycle, in order
	typedef struct packed {
		logic       v0;
		byte_beat_t r0;
		logic       v1;
		byte_beat_t r1;
	} dec_push_t;

endpackage

// File: design/fshb_cell.sv
// One stage of the class history chain with its sync pattern compare.
// Depends on fshb_pkg.
module fshb_cell import fshb_pkg::*; #(
	parameter class_t EXPECT = CLASS_TWO,
	parameter bit     CHECK  = 1'b1
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   shift,
	input  logic   clear,
	input  class_t class_in,
	output class_t class_out,
	input  logic   hit_in,
	output logic   hit_out
);

	class_t class_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			class_q <= CLASS_TWO;
		end else if (clear) begin
			class_q <= CLASS_TWO;
		end else if (shift) begin
			class_q <= class_in;
		end
	end

	assign class_out = class_q;

	// Pass the running match on; a stage without a pattern slot passes it untouched
	assign hit_out = hit_in & (!CHECK || (class_q == EXPECT));

endmodule

// File: design/fshb_decode.sv
// Bit cell decoder: cell position, byte assembly, full and flush handling.
// Produces up to two result beats per cycle. Depends on fshb_pkg.
module fshb_decode import fshb_pkg::*; #(
	parameter int INDEX_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  dec_cmd_t             cmd,
	input  logic [INDEX_WIDTH:0] lim,
	output logic                 hunting,
	output dec_push_t            push
);

	localparam int POS_W = INDEX_WIDTH + 4;
	localparam int BYTE_W = INDEX_WIDTH + 1;
	localparam logic [POS_W-1:0] POS_START = ~POS_W'(1);

	typedef enum logic [1:0] {
		PH_HUNT,
		PH_DECODE,
		PH_FULL
	} phase_t;

	phase_t           phase_q;
	logic [POS_W-1:0] pos_q;
	logic [7:0]       acc_q;

	phase_t            phase_n;
	logic [POS_W-1:0]  pos_n;
	logic [7:0]        acc_n;
	logic [POS_W-1:0]  new_pos;
	logic [BYTE_W-1:0] pos_byte;
	logic [BYTE_W-1:0] new_byte;
	logic              decoding;
	logic              crossed;
	logic              hit_full;
	logic              flush_data;
	logic              no_sync;
	byte_beat_t        cand_a;
	byte_beat_t        cand_b;
	byte_beat_t        cand_c;
	logic              vc;

	assign hunting = (phase_q == PH_HUNT);

	assign new_pos  = pos_q + POS_W'(cmd.code) + POS_W'(2);
	assign pos_byte = pos_q[POS_W-1:3];
	assign new_byte = new_pos[POS_W-1:3];
	assign decoding = cmd.step && (phase_q == PH_DECODE);
	assign crossed  = decoding && !pos_q[POS_W-1] && (pos_byte != new_byte);
	assign hit_full = decoding && (new_byte >= lim);

	always_comb begin
		phase_n = phase_q;
		pos_n   = pos_q;
		acc_n   = acc_q;
		if (cmd.start) begin
			phase_n = PH_DECODE;
			pos_n   = POS_START;
			acc_n   = 8'h00;
		end else if (decoding) begin
			if (hit_full) begin
				phase_n = PH_FULL;
			end else begin
				pos_n = new_pos;
				acc_n = (crossed ? 8'h00 : acc_q) | (8'h80 >> new_pos[2:0]);
			end
		end
	end

	assign flush_data = cmd.flush && (phase_n == PH_DECODE) && !pos_n[POS_W-1];
	assign no_sync    = cmd.flush && (phase_n == PH_HUNT);
	assign vc         = flush_data || no_sync;

	// Candidates in emission order: finished byte, full status, end of capture
	always_comb begin
		cand_a.data_byte  = acc_q;
		cand_a.byte_index = 16'(pos_byte);
		cand_a.status     = STATUS_DATA;
		cand_a.run_end    = 1'b0;

		cand_b.data_byte  = 8'h00;
		cand_b.byte_index = 16'(lim);
		cand_b.status     = STATUS_FULL;
		cand_b.run_end    = 1'b0;

		if (flush_data) begin
			cand_c.data_byte  = acc_n;
			cand_c.byte_index = 16'(pos_n[POS_W-1:3]);
			cand_c.status     = STATUS_DATA;
		end else begin
			cand_c.data_byte  = 8'h00;
			cand_c.byte_index = 16'h0000;
			cand_c.status     = STATUS_NO_SYNC;
		end
		cand_c.run_end = 1'b0;

		push.v0 = crossed || hit_full || vc;
		push.r0 = crossed ? cand_a : (hit_full ? cand_b : cand_c);
		push.v1 = crossed && (hit_full || vc);
		push.r1 = hit_full ? cand_b : cand_c;
		push.r0.run_end = cmd.item_end && !push.v1;
		push.r1.run_end = cmd.item_end;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HUNT;
			pos_q   <= POS_START;
			acc_q   <= 8'h00;
		end else if (cmd.flush) begin
			phase_q <= PH_HUNT;
			pos_q   <= POS_START;
			acc_q   <= 8'h00;
		end else begin
			phase_q <= phase_n;
			pos_q   <= pos_n;
			acc_q   <= acc_n;
		end
	end

endmodule

// File: design/fshb_out_fifo.sv
// Result queue: two write ports, one registered read side, late run_end marking.
// Depends on fshb_pkg.
module fshb_out_fifo import fshb_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  dec_push_t          push,
	input  logic               mark,
	input  logic               hold,
	output logic [LEVEL_W-1:0] level,
	output logic               out_valid,
	input  logic               out_ready,
	output byte_beat_t         out_beat
);

	byte_beat_t         mem_q [FIFO_DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [LEVEL_W-1:0] level_q;

	logic [PTR_W-1:0]   wr_nxt;
	logic [PTR_W-1:0]   wr_prv;
	logic [LEVEL_W-1:0] n_push;
	logic               pop;

	assign wr_nxt = wr_ptr_q + PTR_W'(1);
	assign wr_prv = wr_ptr_q - PTR_W'(1);
	assign n_push = push.v1 ? LEVEL_W'(2) : (push.v0 ? LEVEL_W'(1) : LEVEL_W'(0));

	// Keep the newest beat back while its item may still own the run end
	assign out_valid = (level_q != '0) && !(hold && (level_q == LEVEL_W'(1)));
	assign out_beat  = mem_q[rd_ptr_q];
	assign pop       = out_valid && out_ready;
	assign level     = level_q;

	always_ff @(posedge clk) begin
		if (push.v0) begin
			mem_q[wr_ptr_q] <= push.r0;
		end
		if (push.v1) begin
			mem_q[wr_nxt] <= push.r1;
		end
		if (mark) begin
			mem_q[wr_prv].run_end <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			level_q  <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + n_push[PTR_W-1:0];
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + PTR_W'(1);
			end
			level_q <= level_q + n_push - LEVEL_W'(pop);
		end
	end

endmodule

// File: design/flux_sync_hunt_bit_decoder_unit.sv
// Flux sync hunt bit decoder, top level. Result beats are queued in the
// result queue by the flux beat that causes them; a sync beat's results
// come out during its replay.
// Throughput: 1 flux beat per cycle; a sync match holds input for the whole
// replay (one step per buffered class), and input also waits while the 4-entry
// result queue holds more than 2 beats.
// Reset (arst_n, asynchronous): thresholds 700/500, byte limit 11964, hunting.
// Depends on fshb_pkg, fshb_cell, fshb_decode and fshb_out_fifo.
module flux_sync_hunt_bit_decoder_unit import fshb_pkg::*; #(
	parameter int INDEX_WIDTH = 16
) (
	input  logic              clk,
	input  logic              arst_n,
	// flux interval channel
	input  logic              flux_valid,
	output logic              flux_ready,
	input  flux_beat_t        flux_beat,
	// decoded byte channel
	output logic              byte_valid,
	input  logic              byte_ready,
	output byte_beat_t        byte_beat,
	// configuration
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	localparam int LIM_W = INDEX_WIDTH + 1;
	localparam logic [31:0] LIM_CAP = 32'd1 << INDEX_WIDTH;
	localparam int REPLAY_W = 4;

	// ---------------------------------------------------------------
	// Configuration registers
	// ---------------------------------------------------------------
	logic [15:0] long_q;
	logic [15:0] mid_q;
	logic [15:0] blim_q;
	logic        cfg_wr;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_q <= LONG_LIMIT_RST;
			mid_q  <= MID_LIMIT_RST;
			blim_q <= BYTE_LIMIT_RST;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_LONG_LIMIT: long_q <= pwdata[15:0];
				REG_MID_LIMIT:  mid_q  <= pwdata[15:0];
				REG_BYTE_LIMIT: blim_q <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_LONG_LIMIT: prdata = {16'h0000, long_q};
			REG_MID_LIMIT:  prdata = {16'h0000, mid_q};
			REG_BYTE_LIMIT: prdata = {16'h0000, blim_q};
			default:        prdata = 32'h0000_0000;
		endcase
	end

	// Cap the byte limit at the reach of the byte position
	logic [LIM_W-1:0] lim;
	assign lim = (32'(blim_q) > LIM_CAP) ? LIM_W'(LIM_CAP) : LIM_W'(blim_q);

	// ---------------------------------------------------------------
	// Control
	// ---------------------------------------------------------------
	logic [REPLAY_W-1:0] replay_cnt_q;   // classes still to replay after sync
	logic                replay_final_q; // sync beat was the last of the capture
	logic                item_pushed_q;  // replay has queued at least one beat
	logic [SEEN_W-1:0]   seen_q;

	logic               hunting;
	logic [LEVEL_W-1:0] fifo_level;
	dec_push_t          push;
	dec_cmd_t           cmd;
	logic               accept;
	logic               replay_busy;
	logic               replay_step;
	logic               replay_last;
	logic               match;
	logic               mark;
	class_t             code;

	class_t chain_class [HIST_LEN+1];
	logic   chain_hit   [HIST_LEN+1];

	// Hold input during replay and whenever two more beats might not fit
	assign replay_busy = (replay_cnt_q != '0);
	assign flux_ready  = !replay_busy && (fifo_level <= LEVEL_ROOM);
	assign accept      = flux_valid && flux_ready;
	assign replay_step = replay_busy && (fifo_level <= LEVEL_ROOM);
	assign replay_last = replay_step && (replay_cnt_q == REPLAY_W'(1));

	// Two thresholds give the class
	always_comb begin
		if (flux_beat.interval_time > long_q) begin
			code = CLASS_FOUR;
		end else if (flux_beat.interval_time > mid_q) begin
			code = CLASS_THREE;
		end else begin
			code = CLASS_TWO;
		end
	end

	// ---------------------------------------------------------------
	// Class history chain. Stage 0 holds the newest class. The match is
	// worked out on the history as it will stand after this beat shifts
	// in: the incoming class fills the last pattern slot, stage k fills
	// slot SYNC_LEN-2-k. The two oldest stages take no part in the compare.
	// During replay the chain shifts toward the oldest end and feeds the
	// decoder from there, so it is empty once the replay is done.
	// ---------------------------------------------------------------
	assign chain_class[0] = replay_busy ? CLASS_TWO : code;
	assign chain_hit[0]   = (code == SYNC_CODES[SYNC_LEN-1]) && (seen_q >= SEEN_MAX - 4'd1);

	for (genvar k = 0; k < HIST_LEN; k++) begin : g_cell
		fshb_cell #(
			.EXPECT(SYNC_CODES[(k < SYNC_LEN - 1) ? (SYNC_LEN - 2 - k) : 0]),
			.CHECK (k < SYNC_LEN - 1)
		) u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.shift    ((accept && hunting) || replay_step),
			.clear    (cmd.flush),
			.class_in (chain_class[k]),
			.class_out(chain_class[k+1]),
			.hit_in   (chain_hit[k]),
			.hit_out  (chain_hit[k+1])
		);
	end

	assign match = accept && hunting && chain_hit[HIST_LEN];

	// ---------------------------------------------------------------
	// Decoder command: a flux beat outside the hunt steps directly, a
	// replay cycle steps with the oldest buffered class. The capture's
	// last beat flushes at once, or at the end of its replay.
	// ---------------------------------------------------------------
	always_comb begin
		cmd.start = match;
		cmd.step  = (accept && !hunting) || replay_step;
		cmd.code  = replay_step ? chain_class[HIST_LEN] : code;
		if (accept) begin
			cmd.flush    = flux_beat.final_sample && !match;
			cmd.item_end = !match;
		end else begin
			cmd.flush    = replay_last && replay_final_q;
			cmd.item_end = replay_last;
		end
	end

	fshb_decode #(
		.INDEX_WIDTH(INDEX_WIDTH)
	) u_decode (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.lim    (lim),
		.hunting(hunting),
		.push   (push)
	);

	// A replay whose last step queues nothing ends on the newest queued beat
	assign mark = replay_last && !push.v0 && item_pushed_q;

	// Hold back only a beat of the running replay; older beats stay visible
	fshb_out_fifo u_out_fifo (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.mark     (mark),
		.hold     (replay_busy && item_pushed_q),
		.level    (fifo_level),
		.out_valid(byte_valid),
		.out_ready(byte_ready),
		.out_beat (byte_beat)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			replay_cnt_q   <= '0;
			replay_final_q <= 1'b0;
			item_pushed_q  <= 1'b0;
			seen_q         <= '0;
		end else begin
			if (match) begin
				replay_cnt_q   <= REPLAY_W'(HIST_LEN);
				replay_final_q <= flux_beat.final_sample;
				item_pushed_q  <= 1'b0;
			end else if (replay_step) begin
				replay_cnt_q <= replay_cnt_q - REPLAY_W'(1);
				if (push.v0) begin
					item_pushed_q <= 1'b1;
				end
			end
			// Count hunted intervals, saturate, drop back at capture end
			if (cmd.flush) begin
				seen_q <= '0;
			end else if (accept && hunting && (seen_q < SEEN_MAX)) begin
				seen_q <= seen_q + 4'd1;
			end
		end
	end

	// ---------------------------------------------------------------
	// Checks
	// ---------------------------------------------------------------
	a_replay_not_hunting: assert property (@(posedge clk) disable iff (!arst_n)
		replay_busy |-> !hunting)
		else $error("replay running while decoder hunts");

	a_status_no_data: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_valid && (byte_beat.status != STATUS_DATA)) |-> (byte_beat.data_byte == 8'h00))
		else $error("status beat carries data");

	a_no_sync_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(byte_valid && (byte_beat.status == STATUS_NO_SYNC)) |-> byte_beat.run_end)
		else $error("no sync beat without run end");

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fifo_level <= LEVEL_W'(FIFO_DEPTH))
		else $error("result queue overrun");

endmodule
